// ----- rtl/core/usage_aged_task_picker_assert.svh -----
// Assertion macros for the usage aged task picker checker.
// No dependencies; included by the checker file.
`ifndef USAGE_AGED_TASK_PICKER_ASSERT_SVH
`define USAGE_AGED_TASK_PICKER_ASSERT_SVH

// same-cycle implication
`define UATP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("usage_aged_task_picker: check failed");

// next-cycle implication
`define UATP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("usage_aged_task_picker: check failed");

`endif

// ----- rtl/core/uatp_pkg.sv -----
// Types, constants and microcode ROM for the usage aged task picker.
// No dependencies; used by the top level and its checker.
package uatp_pkg;

   localparam int TASK_SLOTS_DEFAULT = 10;
   localparam int COUNT_W            = 8;
   localparam int TASK_W             = 4;
   localparam int STATUS_W           = 2;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic CMD_CREATE = 1'b0;
   localparam logic CMD_SCHED  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef logic [4:0] step_type;

   localparam step_type STEP_IDLE   = 5'd0;
   localparam step_type STEP_DISP   = 5'd1;
   localparam step_type STEP_CREATE = 5'd2;
   localparam step_type STEP_APPEND = 5'd3;
   localparam step_type STEP_FULL   = 5'd4;
   localparam step_type STEP_SCHED  = 5'd5;
   localparam step_type STEP_START  = 5'd6;
   localparam step_type STEP_BUMP   = 5'd7;
   localparam step_type STEP_FIRST  = 5'd8;
   localparam step_type STEP_LOAD   = 5'd9;
   localparam step_type STEP_SCAN   = 5'd10;
   localparam step_type STEP_PICK   = 5'd11;
   localparam step_type STEP_KEEP   = 5'd12;
   localparam step_type STEP_TAKE   = 5'd13;
   localparam step_type STEP_EMIT   = 5'd14;
   localparam step_type STEP_WAIT   = 5'd15;
   localparam step_type STEP_EMPTY  = 5'd16;

   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_APPEND,
      UOP_SET_FULL,
      UOP_BUMP,
      UOP_FIRST,
      UOP_LOAD,
      UOP_ADVANCE,
      UOP_KEEP,
      UOP_TAKE,
      UOP_SET_EMPTY,
      UOP_EMIT
   } uop_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_SCHED,
      COND_FULL,
      COND_EMPTY,
      COND_NOT_STARTED,
      COND_SCAN_MORE,
      COND_HIT,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      step_type target;
   } ctrl_word_type;

   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      unique case (step)
         STEP_IDLE:   w = '{uop: UOP_NONE,      cond: COND_NO_REQ,      target: STEP_IDLE};
         STEP_DISP:   w = '{uop: UOP_NONE,      cond: COND_SCHED,       target: STEP_SCHED};
         STEP_CREATE: w = '{uop: UOP_NONE,      cond: COND_FULL,        target: STEP_FULL};
         STEP_APPEND: w = '{uop: UOP_APPEND,    cond: COND_ALWAYS,      target: STEP_EMIT};
         STEP_FULL:   w = '{uop: UOP_SET_FULL,  cond: COND_ALWAYS,      target: STEP_EMIT};
         STEP_SCHED:  w = '{uop: UOP_NONE,      cond: COND_EMPTY,       target: STEP_EMPTY};
         STEP_START:  w = '{uop: UOP_NONE,      cond: COND_NOT_STARTED, target: STEP_FIRST};
         STEP_BUMP:   w = '{uop: UOP_BUMP,      cond: COND_ALWAYS,      target: STEP_LOAD};
         STEP_FIRST:  w = '{uop: UOP_FIRST,     cond: COND_NEVER,       target: STEP_IDLE};
         STEP_LOAD:   w = '{uop: UOP_LOAD,      cond: COND_NEVER,       target: STEP_IDLE};
         STEP_SCAN:   w = '{uop: UOP_ADVANCE,   cond: COND_SCAN_MORE,   target: STEP_SCAN};
         STEP_PICK:   w = '{uop: UOP_NONE,      cond: COND_HIT,         target: STEP_TAKE};
         STEP_KEEP:   w = '{uop: UOP_KEEP,      cond: COND_ALWAYS,      target: STEP_EMIT};
         STEP_TAKE:   w = '{uop: UOP_TAKE,      cond: COND_NEVER,       target: STEP_IDLE};
         STEP_EMIT:   w = '{uop: UOP_EMIT,      cond: COND_OUT_FREE,    target: STEP_IDLE};
         STEP_WAIT:   w = '{uop: UOP_NONE,      cond: COND_ALWAYS,      target: STEP_EMIT};
         STEP_EMPTY:  w = '{uop: UOP_SET_EMPTY, cond: COND_ALWAYS,      target: STEP_EMIT};
         default:     w = '{uop: UOP_NONE,      cond: COND_ALWAYS,      target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- rtl/core/usage_aged_task_picker.sv -----
// A create, or a schedule with no tasks, produces its result without a scan; other
// schedules also scan the table entry by entry until one qualifies or all have been examined.
// One item at a time: a result is registered only once the output register holds no
// untaken result, and the next item is taken in the cycle after.
// Reset (synchronous, active high) empties the task table, clears the running task
// and the started flag, and returns the microcode step counter to idle.
module usage_aged_task_picker #(
   parameter int TASK_SLOTS = uatp_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [uatp_pkg::COUNT_W-1:0]  req_initial_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [uatp_pkg::STATUS_W-1:0] rsp_status,
   output logic [uatp_pkg::TASK_W-1:0]   rsp_chosen_task
);

   localparam int CW = $clog2(TASK_SLOTS + 1);
   localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam logic [CW-1:0] SLOTS_C = CW'(TASK_SLOTS);

   uatp_pkg::step_type      pc_ff, pc_in;
   uatp_pkg::ctrl_word_type ctrl;

   logic                         cmd_ff, cmd_in;
   logic [uatp_pkg::COUNT_W-1:0] init_ff, init_in;
   logic [CW-1:0]                task_count_ff, task_count_in;
   logic [IW-1:0]                running_ff, running_in;
   logic                         started_ff, started_in;
   logic [uatp_pkg::COUNT_W-1:0] ref_ff, ref_in;
   logic [IW-1:0]                idx_ff, idx_in;
   logic [CW-1:0]                k_ff, k_in;
   uatp_pkg::status_type         res_status_ff, res_status_in;
   logic [uatp_pkg::TASK_W-1:0]  res_task_ff, res_task_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   uatp_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [uatp_pkg::TASK_W-1:0]  rsp_task_ff, rsp_task_in;

   logic [uatp_pkg::COUNT_W-1:0] counts_ff [TASK_SLOTS];

   logic                         req_accept;
   logic                         out_free;
   logic [IW-1:0]                rd_addr;
   logic [uatp_pkg::COUNT_W-1:0] rd_data;
   logic                         wr_en;
   logic [IW-1:0]                wr_addr;
   logic [uatp_pkg::COUNT_W-1:0] wr_data;
   logic [IW-1:0]                step_src;
   logic [CW-1:0]                step_p1;
   logic [IW-1:0]                step_next;
   logic                         in_range;
   logic                         hit;
   logic                         scan_more;
   logic                         cond_true;

   assign ctrl       = uatp_pkg::ucode_rom(pc_ff);
   assign req_stall  = (pc_ff != uatp_pkg::STEP_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign rd_addr = ((ctrl.uop == uatp_pkg::UOP_BUMP) || (ctrl.uop == uatp_pkg::UOP_LOAD))
                    ? running_ff : idx_ff;
   assign rd_data = counts_ff[rd_addr];

   assign step_src  = (ctrl.uop == uatp_pkg::UOP_LOAD) ? running_ff : idx_ff;
   assign step_p1   = CW'(step_src) + CW'(1);
   assign step_next = (step_p1 == task_count_ff) ? '0 : step_p1[IW-1:0];

   assign in_range  = (k_ff < task_count_ff);
   assign hit       = in_range && (rd_data < ref_ff);
   assign scan_more = in_range && !(rd_data < ref_ff);

   always_comb begin
      unique case (ctrl.cond)
         uatp_pkg::COND_NEVER:       cond_true = 1'b0;
         uatp_pkg::COND_ALWAYS:      cond_true = 1'b1;
         uatp_pkg::COND_NO_REQ:      cond_true = !req_valid;
         uatp_pkg::COND_SCHED:       cond_true = (cmd_ff == uatp_pkg::CMD_SCHED);
         uatp_pkg::COND_FULL:        cond_true = (task_count_ff >= SLOTS_C);
         uatp_pkg::COND_EMPTY:       cond_true = (task_count_ff == '0);
         uatp_pkg::COND_NOT_STARTED: cond_true = !started_ff;
         uatp_pkg::COND_SCAN_MORE:   cond_true = scan_more;
         uatp_pkg::COND_HIT:         cond_true = hit;
         uatp_pkg::COND_OUT_FREE:    cond_true = out_free;
         default:                    cond_true = 1'b0;
      endcase
   end

   always_comb begin
      pc_in         = cond_true ? ctrl.target : pc_ff + uatp_pkg::step_type'(1);
      cmd_in        = cmd_ff;
      init_in       = init_ff;
      task_count_in = task_count_ff;
      running_in    = running_ff;
      started_in    = started_ff;
      ref_in        = ref_ff;
      idx_in        = idx_ff;
      k_in          = k_ff;
      res_status_in = res_status_ff;
      res_task_in   = res_task_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      wr_en         = 1'b0;
      wr_addr       = running_ff;
      wr_data       = rd_data + uatp_pkg::COUNT_W'(1);

      if (req_accept) begin
         cmd_in  = req_command;
         init_in = req_initial_count;
      end

      unique case (ctrl.uop)
         uatp_pkg::UOP_NONE: begin
         end
         uatp_pkg::UOP_APPEND: begin
            wr_en         = 1'b1;
            wr_addr       = task_count_ff[IW-1:0];
            wr_data       = init_ff;
            task_count_in = task_count_ff + CW'(1);
            res_status_in = uatp_pkg::STATUS_OK;
            res_task_in   = uatp_pkg::TASK_W'(task_count_ff);
         end
         uatp_pkg::UOP_SET_FULL: begin
            res_status_in = uatp_pkg::STATUS_FULL;
            res_task_in   = '0;
         end
         uatp_pkg::UOP_BUMP: begin
            wr_en = (CW'(running_ff) < task_count_ff) && (rd_data != uatp_pkg::COUNT_MAX);
         end
         uatp_pkg::UOP_FIRST: begin
            started_in = 1'b1;
            running_in = '0;
         end
         uatp_pkg::UOP_LOAD: begin
            ref_in = rd_data;
            idx_in = step_next;
            k_in   = CW'(1);
         end
         uatp_pkg::UOP_ADVANCE: begin
            if (scan_more) begin
               idx_in = step_next;
               k_in   = k_ff + CW'(1);
            end
         end
         uatp_pkg::UOP_KEEP: begin
            res_status_in = uatp_pkg::STATUS_OK;
            res_task_in   = uatp_pkg::TASK_W'(running_ff);
         end
         uatp_pkg::UOP_TAKE: begin
            running_in    = idx_ff;
            res_status_in = uatp_pkg::STATUS_OK;
            res_task_in   = uatp_pkg::TASK_W'(idx_ff);
         end
         uatp_pkg::UOP_SET_EMPTY: begin
            res_status_in = uatp_pkg::STATUS_EMPTY;
            res_task_in   = '0;
         end
         uatp_pkg::UOP_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_task_in   = res_task_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= uatp_pkg::STEP_IDLE;
         task_count_ff <= '0;
         running_ff    <= '0;
         started_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         task_count_ff <= task_count_in;
         running_ff    <= running_in;
         started_ff    <= started_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      init_ff       <= init_in;
      ref_ff        <= ref_in;
      idx_ff        <= idx_in;
      k_ff          <= k_in;
      res_status_ff <= res_status_in;
      res_task_ff   <= res_task_in;
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
      if (wr_en) begin
         counts_ff[wr_addr] <= wr_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_chosen_task = rsp_task_ff;

endmodule

// ----- rtl/core/uatp_checker.sv -----
// Port-level checker for the usage aged task picker, bound to the top level.
// Depends on uatp_pkg and usage_aged_task_picker_assert.svh.
`include "usage_aged_task_picker_assert.svh"

module uatp_checker #(
   parameter int TASK_SLOTS = uatp_pkg::TASK_SLOTS_DEFAULT
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_command,
   input logic [uatp_pkg::COUNT_W-1:0]  req_initial_count,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [uatp_pkg::STATUS_W-1:0] rsp_status,
   input logic [uatp_pkg::TASK_W-1:0]   rsp_chosen_task
);

   localparam logic [uatp_pkg::TASK_W:0] SLOTS_C = (uatp_pkg::TASK_W + 1)'(TASK_SLOTS);

   logic unused_payload;
   assign unused_payload = req_command ^ (^req_initial_count);

   `UATP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `UATP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
                     $stable(rsp_status) && $stable(rsp_chosen_task))
   `UATP_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall)
   `UATP_ASSERT_NOW(a_err_task_zero, clock, reset,
                    rsp_valid && (rsp_status != uatp_pkg::STATUS_OK), rsp_chosen_task == '0)
   `UATP_ASSERT_NOW(a_task_in_table, clock, reset,
                    rsp_valid && (rsp_status == uatp_pkg::STATUS_OK),
                    {1'b0, rsp_chosen_task} < SLOTS_C)

endmodule

bind usage_aged_task_picker uatp_checker #(
   .TASK_SLOTS(TASK_SLOTS)
) u_uatp_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .req_command       (req_command),
   .req_initial_count (req_initial_count),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_chosen_task   (rsp_chosen_task)
);
